FILE: src/rotating_frame_body_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotating-frame body stepper
// Concurrent checks on clk with rst_n as disable; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTATING_FRAME_BODY_STEP_MACROS_SVH
`define ROTATING_FRAME_BODY_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define RFBS_ASSERT_IMPL(lbl, a, b) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (a) |-> (b)) else $error("rfbs check failed");
`define RFBS_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (a) |=> (b)) else $error("rfbs check failed");
`else
`define RFBS_ASSERT_IMPL(lbl, a, b)
`define RFBS_ASSERT_NEXT(lbl, a, b)
`endif
`endif

FILE: src/rfbs_pkg.sv
// ----------------------------------------------------------------------------
// rfbs_pkg
// Widths, constants, request types and helpers for the body stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rfbs_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RES_W  = 52;
    localparam int SUM_W  = 56;
    localparam int ANG_W  = 36;
    localparam int CRD_W  = 36;
    localparam int SH_W   = 6;

    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1686629713);
    localparam logic signed [MUL_W-1:0] CORDIC_GAIN = MUL_W'(64'sd652032874);

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
        logic [SH_W-1:0]         sh;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
    } cord_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } cord_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
        lo = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
        if (v > hi)
            return hi[31:0];
        else if (v < lo)
            return lo[31:0];
        else
            return v[31:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;
            5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return $signed({{(ANG_W-32){1'b0}}, t});
    endfunction

endpackage

FILE: src/rfbs_mul.sv
// ----------------------------------------------------------------------------
// rfbs_mul
// Shared signed multiplier; registered product, then round-to-nearest
// (ties away from zero) right shift by the requested amount.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rfbs_mul
    import rfbs_pkg::*;
(
    input  logic                    clk,
    input  mul_req_t                req,
    output logic signed [RES_W-1:0] res
);

    logic signed [MUL_W-1:0]  a_s;
    logic signed [MUL_W-1:0]  b_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SH_W-1:0]          sh_next;
    logic [SH_W-1:0]          sh_reg;
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        rnd;
    logic [PROD_W-1:0]        mag_r;

    assign a_s       = req.a;
    assign b_s       = req.b;
    assign prod_next = a_s * b_s;
    assign sh_next   = req.sh;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
    end

    always_comb
    begin
        neg   = prod_reg[PROD_W-1];
        mag   = neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        rnd   = (sh_reg == '0) ? '0 : (PROD_W'(1) << (sh_reg - SH_W'(1)));
        mag_r = (mag + rnd) >> sh_reg;
        res   = neg ? -$signed(mag_r[RES_W-1:0]) : $signed(mag_r[RES_W-1:0]);
    end

endmodule

FILE: src/rfbs_cordic.sv
// ----------------------------------------------------------------------------
// rfbs_cordic
// Iterative z-rotation: folds the angle into +-pi/2, then one micro-rotation
// per cycle; output clamped to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rfbs_cordic
    import rfbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cord_req_t req,
    output cord_rsp_t rsp
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RED  = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    logic [1:0]              cst_reg,  cst_next;
    logic [5:0]              i_reg,    i_next;
    logic                    done_reg, done_next;
    logic signed [CRD_W-1:0] x_reg,    x_next;
    logic signed [CRD_W-1:0] y_reg,    y_next;
    logic signed [ANG_W-1:0] ang_reg,  ang_next;

    always_comb
    begin
        cst_next  = cst_reg;
        i_next    = i_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        case (cst_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    x_next   = req.x;
                    y_next   = req.y;
                    ang_next = req.ang;
                    cst_next = C_RED;
                end
            end
            C_RED:
            begin
                if (ang_reg > ANG_HALF_PI)
                begin
                    ang_next = ang_reg - ANG_PI;
                    x_next   = -x_reg;
                    y_next   = -y_reg;
                end
                else if (ang_reg < -ANG_HALF_PI)
                begin
                    ang_next = ang_reg + ANG_PI;
                    x_next   = -x_reg;
                    y_next   = -y_reg;
                end
                else
                begin
                    i_next   = '0;
                    cst_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (ang_reg >= 0)
                begin
                    x_next   = x_reg - (y_reg >>> i_reg[4:0]);
                    y_next   = y_reg + (x_reg >>> i_reg[4:0]);
                    ang_next = ang_reg - atan_val(i_reg[4:0]);
                end
                else
                begin
                    x_next   = x_reg + (y_reg >>> i_reg[4:0]);
                    y_next   = y_reg - (x_reg >>> i_reg[4:0]);
                    ang_next = ang_reg + atan_val(i_reg[4:0]);
                end
                i_next = i_reg + 6'd1;
                if (i_reg == 6'(CORDIC_STEPS - 1))
                begin
                    cst_next  = C_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                cst_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg  <= C_IDLE;
            i_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cst_reg  <= cst_next;
            i_reg    <= i_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = sat32(SUM_W'(x_reg));
    assign rsp.y    = sat32(SUM_W'(y_reg));

endmodule

FILE: src/rotating_frame_body_step.sv
// ----------------------------------------------------------------------------
// rotating_frame_body_step
// Position and velocity of one body in a frame spinning about z; load and
// step items, one result item each.
// ----------------------------------------------------------------------------
// A load item passes through ST_FIN into the output register. A centrifugal
// Verlet step issues 14 products on the one shared 33x33 multiplier. An exact
// rotating-frame step issues 19 products and two CORDIC rotations, each an
// angle fold by pi into +-pi/2 then 24 micro-rotations. One item is in work at
// a time; the result sits in an output register so the next item may be taken
// while it waits.
`timescale 1ns / 1ps
`include "rotating_frame_body_step_macros.svh"
module rotating_frame_body_step
    import rfbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] load_pos_x,
    input  logic signed [31:0] load_pos_y,
    input  logic signed [31:0] load_pos_z,
    input  logic signed [31:0] load_vel_x,
    input  logic signed [31:0] load_vel_y,
    input  logic signed [31:0] load_vel_z,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic [15:0]        time_step,
    input  logic               coriolis_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_CORD = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [4:0] V_LAST = 5'd13;
    localparam logic [4:0] I_LAST = 5'd18;
    localparam logic [4:0] I_ROTP = 5'd14;
    localparam logic [4:0] I_ROTV = 5'd16;
    localparam logic [4:0] I_PRET = 5'd15;

    logic [1:0]              state_reg, state_next;
    logic [4:0]              pc_reg,    pc_next;
    logic                    phase_reg, phase_next;
    logic                    mode_reg,  mode_next;
    logic signed [31:0]      w_reg,     w_next;
    logic signed [31:0]      acc_reg [3];
    logic signed [31:0]      acc_next [3];
    logic [15:0]             dt_reg,    dt_next;
    logic signed [31:0]      pos_reg [3];
    logic signed [31:0]      pos_next [3];
    logic signed [31:0]      vel_reg [3];
    logic signed [31:0]      vel_next [3];
    logic [31:0]             w2_reg,    w2_next;
    logic [31:0]             dt2_reg,   dt2_next;
    logic signed [31:0]      s_reg,     s_next;
    logic signed [SUM_W-1:0] t_reg,     t_next;
    logic signed [ANG_W-1:0] ang_reg,   ang_next;
    logic signed [CRD_W-1:0] cx_reg,    cx_next;
    logic signed [CRD_W-1:0] cy_reg,    cy_next;
    logic                    cst_reg,   cst_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [31:0]      opos_reg [3];
    logic signed [31:0]      opos_next [3];
    logic signed [31:0]      ovel_reg [3];
    logic signed [31:0]      ovel_next [3];

    mul_req_t                mreq;
    logic signed [RES_W-1:0] r;
    logic signed [SUM_W-1:0] rs;
    cord_req_t               creq;
    cord_rsp_t               crsp;
    logic                    cord_done;
    logic                    accept;

    rfbs_mul u_mul (
        .clk (clk),
        .req (mreq),
        .res (r)
    );

    assign creq.start = cst_reg;
    assign creq.x     = cx_reg;
    assign creq.y     = cy_reg;
    assign creq.ang   = ang_reg;

    rfbs_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign cord_done = crsp.done;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign rs        = SUM_W'(r);

    // operand selection per program step
    always_comb
    begin
        mreq.a  = MUL_W'(w_reg);
        mreq.b  = MUL_W'(w_reg);
        mreq.sh = SH_W'(32);
        if (!mode_reg)
        begin
            case (pc_reg)
                5'd0:  begin mreq.a = MUL_W'(w_reg);      mreq.b = MUL_W'(w_reg);
                             mreq.sh = SH_W'(32); end
                5'd1:  begin mreq.a = MUL_W'(w2_reg);     mreq.b = MUL_W'(pos_reg[0]);
                             mreq.sh = SH_W'(24); end
                5'd2:  begin mreq.a = MUL_W'(s_reg);      mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
                5'd3:  begin mreq.a = MUL_W'(vel_reg[0]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd4:  begin mreq.a = MUL_W'(w2_reg);     mreq.b = MUL_W'(pos_reg[1]);
                             mreq.sh = SH_W'(24); end
                5'd5:  begin mreq.a = MUL_W'(s_reg);      mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
                5'd6:  begin mreq.a = MUL_W'(vel_reg[1]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd7:  begin mreq.a = MUL_W'(acc_reg[2]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
                5'd8:  begin mreq.a = MUL_W'(vel_reg[2]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd9:  begin mreq.a = MUL_W'(w2_reg);     mreq.b = MUL_W'(pos_reg[0]);
                             mreq.sh = SH_W'(24); end
                5'd10: begin mreq.a = MUL_W'(s_reg);      mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
                5'd11: begin mreq.a = MUL_W'(w2_reg);     mreq.b = MUL_W'(pos_reg[1]);
                             mreq.sh = SH_W'(24); end
                5'd12: begin mreq.a = MUL_W'(s_reg);      mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
                default: begin mreq.a = MUL_W'(acc_reg[2]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(17); end
            endcase
        end
        else
        begin
            case (pc_reg)
                5'd0:  begin mreq.a = MUL_W'(w_reg);      mreq.b = MUL_W'(pos_reg[1]);
                             mreq.sh = SH_W'(28); end
                5'd1:  begin mreq.a = MUL_W'(w_reg);      mreq.b = MUL_W'(pos_reg[0]);
                             mreq.sh = SH_W'(28); end
                5'd2:  begin mreq.a = MUL_W'(dt_reg);     mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(0); end
                5'd3:  begin mreq.a = MUL_W'(vel_reg[0]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd4:  begin mreq.a = MUL_W'(acc_reg[0]); mreq.b = MUL_W'(dt2_reg);
                             mreq.sh = SH_W'(33); end
                5'd5:  begin mreq.a = MUL_W'(acc_reg[0]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd6:  begin mreq.a = MUL_W'(vel_reg[1]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd7:  begin mreq.a = MUL_W'(acc_reg[1]); mreq.b = MUL_W'(dt2_reg);
                             mreq.sh = SH_W'(33); end
                5'd8:  begin mreq.a = MUL_W'(acc_reg[1]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd9:  begin mreq.a = MUL_W'(vel_reg[2]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd10: begin mreq.a = MUL_W'(acc_reg[2]); mreq.b = MUL_W'(dt2_reg);
                             mreq.sh = SH_W'(33); end
                5'd11: begin mreq.a = MUL_W'(acc_reg[2]); mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(16); end
                5'd12: begin mreq.a = MUL_W'(w_reg);      mreq.b = MUL_W'(dt_reg);
                             mreq.sh = SH_W'(14); end
                5'd13: begin mreq.a = MUL_W'(pos_reg[0]); mreq.b = CORDIC_GAIN;
                             mreq.sh = SH_W'(30); end
                5'd14: begin mreq.a = MUL_W'(pos_reg[1]); mreq.b = CORDIC_GAIN;
                             mreq.sh = SH_W'(30); end
                5'd15: begin mreq.a = MUL_W'(vel_reg[0]); mreq.b = CORDIC_GAIN;
                             mreq.sh = SH_W'(30); end
                5'd16: begin mreq.a = MUL_W'(vel_reg[1]); mreq.b = CORDIC_GAIN;
                             mreq.sh = SH_W'(30); end
                5'd17: begin mreq.a = MUL_W'(w_reg);      mreq.b = MUL_W'(pos_reg[1]);
                             mreq.sh = SH_W'(28); end
                default: begin mreq.a = MUL_W'(w_reg);    mreq.b = MUL_W'(pos_reg[0]);
                             mreq.sh = SH_W'(28); end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        w_next     = w_reg;
        dt_next    = dt_reg;
        w2_next    = w2_reg;
        dt2_next   = dt2_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        ang_next   = ang_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cst_next   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k]  = acc_reg[k];
            pos_next[k]  = pos_reg[k];
            vel_next[k]  = vel_reg[k];
            opos_next[k] = opos_reg[k];
            ovel_next[k] = ovel_reg[k];
        end
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid)
            w_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        pos_next[0] = load_pos_x;
                        pos_next[1] = load_pos_y;
                        pos_next[2] = load_pos_z;
                        vel_next[0] = load_vel_x;
                        vel_next[1] = load_vel_y;
                        vel_next[2] = load_vel_z;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        acc_next[0] = accel_x;
                        acc_next[1] = accel_y;
                        acc_next[2] = accel_z;
                        dt_next     = time_step;
                        mode_next   = coriolis_mode;
                        pc_next     = '0;
                        phase_next  = 1'b0;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    pc_next = pc_reg + 5'd1;
                    if (!mode_reg)
                    begin
                        case (pc_reg)
                            5'd0:  w2_next = r[31:0];
                            5'd1:  s_next = sat32(SUM_W'(sat32(rs)) + SUM_W'(acc_reg[0]));
                            5'd2:  vel_next[0] = sat32(SUM_W'(vel_reg[0]) + rs);
                            5'd3:  pos_next[0] = sat32(SUM_W'(pos_reg[0]) + rs);
                            5'd4:  s_next = sat32(SUM_W'(sat32(rs)) + SUM_W'(acc_reg[1]));
                            5'd5:  vel_next[1] = sat32(SUM_W'(vel_reg[1]) + rs);
                            5'd6:  pos_next[1] = sat32(SUM_W'(pos_reg[1]) + rs);
                            5'd7:  vel_next[2] = sat32(SUM_W'(vel_reg[2]) + rs);
                            5'd8:  pos_next[2] = sat32(SUM_W'(pos_reg[2]) + rs);
                            5'd9:  s_next = sat32(SUM_W'(sat32(rs)) + SUM_W'(acc_reg[0]));
                            5'd10: vel_next[0] = sat32(SUM_W'(vel_reg[0]) + rs);
                            5'd11: s_next = sat32(SUM_W'(sat32(rs)) + SUM_W'(acc_reg[1]));
                            5'd12: vel_next[1] = sat32(SUM_W'(vel_reg[1]) + rs);
                            default: vel_next[2] = sat32(SUM_W'(vel_reg[2]) + rs);
                        endcase
                        if (pc_reg == V_LAST)
                            state_next = ST_FIN;
                    end
                    else
                    begin
                        case (pc_reg)
                            5'd0:  vel_next[0] = sat32(SUM_W'(vel_reg[0]) - rs);
                            5'd1:  vel_next[1] = sat32(SUM_W'(vel_reg[1]) + rs);
                            5'd2:  dt2_next = r[31:0];
                            5'd3:  t_next = SUM_W'(pos_reg[0]) + rs;
                            5'd4:  pos_next[0] = sat32(t_reg + rs);
                            5'd5:  vel_next[0] = sat32(SUM_W'(vel_reg[0]) + rs);
                            5'd6:  t_next = SUM_W'(pos_reg[1]) + rs;
                            5'd7:  pos_next[1] = sat32(t_reg + rs);
                            5'd8:  vel_next[1] = sat32(SUM_W'(vel_reg[1]) + rs);
                            5'd9:  t_next = SUM_W'(pos_reg[2]) + rs;
                            5'd10: pos_next[2] = sat32(t_reg + rs);
                            5'd11: vel_next[2] = sat32(SUM_W'(vel_reg[2]) + rs);
                            5'd12: ang_next = ANG_W'(-rs);
                            5'd13: cx_next = $signed(r[CRD_W-1:0]);
                            5'd14: cy_next = $signed(r[CRD_W-1:0]);
                            5'd15: cx_next = $signed(r[CRD_W-1:0]);
                            5'd16: cy_next = $signed(r[CRD_W-1:0]);
                            5'd17: vel_next[0] = sat32(SUM_W'(vel_reg[0]) + rs);
                            default: vel_next[1] = sat32(SUM_W'(vel_reg[1]) - rs);
                        endcase
                        if (pc_reg == I_ROTP || pc_reg == I_ROTV)
                        begin
                            cst_next   = 1'b1;
                            state_next = ST_CORD;
                        end
                        if (pc_reg == I_LAST)
                            state_next = ST_FIN;
                    end
                end
            end
            ST_CORD:
            begin
                if (cord_done)
                begin
                    if (pc_reg == I_PRET)
                    begin
                        pos_next[0] = crsp.x;
                        pos_next[1] = crsp.y;
                    end
                    else
                    begin
                        vel_next[0] = crsp.x;
                        vel_next[1] = crsp.y;
                    end
                    phase_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        opos_next[k] = pos_reg[k];
                        ovel_next[k] = vel_reg[k];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            phase_reg     <= 1'b0;
            cst_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= '0;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            cst_reg       <= cst_next;
            out_valid_reg <= out_valid_next;
            w_reg         <= w_next;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= pos_next[k];
                vel_reg[k] <= vel_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        dt_reg   <= dt_next;
        w2_reg   <= w2_next;
        dt2_reg  <= dt2_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        ang_reg  <= ang_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        for (int k = 0; k < 3; k++)
        begin
            acc_reg[k]  <= acc_next[k];
            opos_reg[k] <= opos_next[k];
            ovel_reg[k] <= ovel_next[k];
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = opos_reg[0];
    assign pos_y     = opos_reg[1];
    assign pos_z     = opos_reg[2];
    assign vel_x     = ovel_reg[0];
    assign vel_y     = ovel_reg[1];
    assign vel_z     = ovel_reg[2];

    `RFBS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `RFBS_ASSERT_IMPL(a_cord_done_in_wait, cord_done, state_reg == ST_CORD)
    `RFBS_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN)

endmodule

FILE: tb/sv/rotating_frame_body_step_tb.sv
// ----------------------------------------------------------------------------
// rotating_frame_body_step_tb
// Drives load and step items through the body stepper under several spin
// rates, predicts each result state in fixed point and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rotating_frame_body_step_tb;
    import rfbs_pkg::*;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
    } body_state_t;

    class state_scoreboard;
        body_state_t pending[$];
        int errors;
        int checked;
        longint pos [3];
        longint vel [3];
        longint rate;

        function new();
            errors = 0;
            checked = 0;
            rate = 0;
            for (int k = 0; k < 3; k++)
            begin
                pos[k] = 0;
                vel[k] = 0;
            end
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint mulr(longint a, longint b, int sh);
            longint pr;
            longint unsigned mag;
            pr = a * b;
            mag = pr < 0 ? -pr : pr;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return pr < 0 ? -longint'(mag) : longint'(mag);
        endfunction

        function longint floor_shr(longint x, int s);
            return x >>> s;
        endfunction

        function void spin(inout longint x, inout longint y, input longint ang);
            longint cx, cy, dx, dy;
            cx = x;
            cy = y;
            for (int i = 0; i < 8 && ang > 64'sd1686629713; i++)
            begin
                ang -= 64'sd3373259426;
                cx = -cx;
                cy = -cy;
            end
            for (int i = 0; i < 8 && ang < -64'sd1686629713; i++)
            begin
                ang += 64'sd3373259426;
                cx = -cx;
                cy = -cy;
            end
            cx = mulr(cx, 64'sd652032874, 30);
            cy = mulr(cy, 64'sd652032874, 30);
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = floor_shr(cy, i);
                dy = floor_shr(cx, i);
                if (ang >= 0)
                begin
                    cx -= dx;
                    cy += dy;
                    ang -= longint'(atan_val(5'(i)));
                end
                else
                begin
                    cx += dx;
                    cy -= dy;
                    ang += longint'(atan_val(5'(i)));
                end
            end
            x = clamp(cx);
            y = clamp(cy);
        endfunction

        function void centrifugal_step(longint acc [3], longint dt);
            longint w2, c, s;
            longint half [3];
            w2 = mulr(rate, rate, 32);
            for (int k = 0; k < 3; k++)
            begin
                c = k < 2 ? clamp(mulr(w2, pos[k], 24)) : 0;
                s = clamp(c + acc[k]);
                half[k] = clamp(vel[k] + mulr(s, dt, 17));
                pos[k] = clamp(pos[k] + mulr(half[k], dt, 16));
            end
            for (int k = 0; k < 3; k++)
            begin
                c = k < 2 ? clamp(mulr(w2, pos[k], 24)) : 0;
                s = clamp(c + acc[k]);
                vel[k] = clamp(half[k] + mulr(s, dt, 17));
            end
        endfunction

        function void inertial_step(longint acc [3], longint dt);
            longint vi [3];
            longint px, py, vx, vy, ang;
            vi[0] = clamp(vel[0] - mulr(rate, pos[1], 28));
            vi[1] = clamp(vel[1] + mulr(rate, pos[0], 28));
            vi[2] = vel[2];
            for (int k = 0; k < 3; k++)
            begin
                pos[k] = clamp(pos[k] + mulr(vi[k], dt, 16) + mulr(acc[k], dt * dt, 33));
                vel[k] = clamp(vi[k] + mulr(acc[k], dt, 16));
            end
            ang = -mulr(rate, dt, 14);
            px = pos[0];
            py = pos[1];
            vx = vel[0];
            vy = vel[1];
            spin(px, py, ang);
            spin(vx, vy, ang);
            pos[0] = px;
            pos[1] = py;
            vel[0] = clamp(vx + mulr(rate, py, 28));
            vel[1] = clamp(vy - mulr(rate, px, 28));
        endfunction

        function void note_item(logic o, logic signed [31:0] lp [3],
                                logic signed [31:0] lv [3], logic signed [31:0] ac [3],
                                logic [15:0] dt, logic mode);
            longint acc [3];
            body_state_t e;
            if (!o)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pos[k] = lp[k];
                    vel[k] = lv[k];
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                    acc[k] = ac[k];
                if (mode)
                    inertial_step(acc, longint'(dt));
                else
                    centrifugal_step(acc, longint'(dt));
            end
            for (int k = 0; k < 3; k++)
            begin
                e.p[k] = pos[k][31:0];
                e.v[k] = vel[k][31:0];
            end
            pending.push_back(e);
        endfunction

        task check_result(body_state_t got);
            body_state_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, 0);
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 3; k++)
            begin
                if (got.p[k] !== e.p[k])
                    report_mismatch($sformatf("pos[%0d]", k), got.p[k], e.p[k]);
                if (got.v[k] !== e.v[k])
                    report_mismatch($sformatf("vel[%0d]", k), got.v[k], e.v[k]);
            end
        endtask

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 50)
                $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic op = 0;
    logic signed [31:0] load_pos_x = 0, load_pos_y = 0, load_pos_z = 0;
    logic signed [31:0] load_vel_x = 0, load_vel_y = 0, load_vel_z = 0;
    logic signed [31:0] accel_x = 0, accel_y = 0, accel_z = 0;
    logic [15:0] time_step = 0;
    logic coriolis_mode = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic signed [31:0] cfg_data = 0;

    state_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    longint cycle = 0;
    int items_sent = 0;
    int rates_used = 0;

    always #1 clk = ~clk;

    rotating_frame_body_step dut (.*);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 2000000)
        begin
            $display("Timeout at cycle %0d", cycle);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: sample and stall choice at the same edge
    always @(posedge clk)
    begin
        body_state_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.p[0] = pos_x;
            got.p[1] = pos_y;
            got.p[2] = pos_z;
            got.v[0] = vel_x;
            got.v[1] = vel_y;
            got.v[2] = vel_z;
            board.check_result(got);
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh000FFFFF;
        endcase
    endfunction

    task automatic send_item(logic o, logic signed [31:0] lp [3], logic signed [31:0] lv [3],
                             logic signed [31:0] ac [3], logic [15:0] dt, logic mode);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        op <= o;
        load_pos_x <= lp[0];
        load_pos_y <= lp[1];
        load_pos_z <= lp[2];
        load_vel_x <= lv[0];
        load_vel_y <= lv[1];
        load_vel_z <= lv[2];
        accel_x <= ac[0];
        accel_y <= ac[1];
        accel_z <= ac[2];
        time_step <= dt;
        coriolis_mode <= mode;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(o, lp, lv, ac, dt, mode);
        items_sent++;
    endtask

    task automatic send_random();
        logic signed [31:0] lp [3], lv [3], ac [3];
        logic [15:0] dt;
        for (int k = 0; k < 3; k++)
        begin
            lp[k] = rand_vec();
            lv[k] = rand_vec();
            ac[k] = rand_vec();
        end
        case ($urandom_range(3))
            0: dt = $urandom;
            1: dt = 16'hFFFF;
            default: dt = $urandom_range(0, 2000);
        endcase
        send_item($urandom_range(4) != 0, lp, lv, ac, dt, $urandom_range(1));
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_rate(logic signed [31:0] w);
        cfg_valid <= 1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        board.rate = w;
        rates_used++;
    endtask

    initial
    begin
        logic signed [31:0] lp [3], lv [3], ac [3];
        logic signed [31:0] rates [6];
        rates = '{32'sh10000000, 32'sh7FFFFFFF, 32'sh80000000, -32'sh02000000,
                  32'sh00400000, 32'sh0};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, both ops, both modes
        lp = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000};
        lv = '{32'sh80000000, 32'sh7FFFFFFF, -32'sh00010000};
        ac = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0};
        send_item(0, lp, lv, ac, 16'h0, 0);
        send_item(1, lp, lv, ac, 16'hFFFF, 0);
        send_item(1, lp, lv, ac, 16'hFFFF, 1);
        send_item(1, lp, lv, ac, 16'h0, 1);
        drain();
        set_rate(32'sh7FFFFFFF);
        send_item(0, lp, lv, ac, 16'h0, 0);
        send_item(1, lp, lv, ac, 16'hFFFF, 1);
        send_item(1, lp, lv, ac, 16'hFFFF, 0);
        drain();
        set_rate(32'sh80000000);
        lp = '{32'sh00010000, 32'sh00020000, 32'sh0};
        lv = '{32'sh0, 32'sh00010000, 32'sh0};
        send_item(0, lp, lv, ac, 16'h0, 0);
        for (int i = 0; i < 6; i++)
            send_item(1, lp, lv, '{32'sh0, 32'sh0, 32'sh00010000},
                      16'(i * 13000 + 1), i[0]);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_rate(ph == 5 ? $urandom : rates[ph]);
            send_idle_pct = ph < 2 ? 30 : (ph < 4 ? 57 : 0);
            recv_idle_pct = ph < 2 ? 57 : (ph < 4 ? 30 : 0);
            if (ph == 1)
                hold_cycles = 600;
            for (int i = 0; i < 180; i++)
                send_random();
            if (ph == 3)
                drain();
            for (int i = 0; i < 3; i++)
                send_random();
            drain();
        end

        $display("Sent %0d items across %0d spin rates, both step modes and loads.",
                 items_sent, rates_used);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
